/* hdl/drm_pkg.sv */
`default_nettype none
package drm_pkg;

    // Per-ring storage depth in bytes; must be a power of two.
    localparam int MAX_RING_BYTES = 4096;
    localparam int RING_AW        = $clog2(MAX_RING_BYTES);
    localparam int CNT_W          = RING_AW + 1;
    localparam int NUM_RINGS      = 4;
    localparam int RING_IDX_W     = $clog2(NUM_RINGS);
    localparam int RAM_AW         = RING_IDX_W + RING_AW;

    localparam int CFG_W          = 4;
    localparam int CFG_IDX_W      = 1;
    localparam int BELL_W         = 32;

    localparam int LOG2_LO        = 4;
    localparam int LOG2_HI        = (RING_AW < 12) ? RING_AW : 12;
    localparam logic [CFG_W-1:0] CAP_LOG2_RESET = CFG_W'(12);

    localparam int IN_TDATA_W     = 16;
    localparam int OUT_TDATA_W    = 48;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CONTROL_CAP = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_BULK_CAP    = 1'b1;

    typedef enum logic [2:0] {
        OP_WRITE   = 3'd0,
        OP_READ    = 3'd1,
        OP_CLOSE   = 3'd2,
        OP_PREPARE = 3'd3,
        OP_FINISH  = 3'd4,
        OP_QUERY   = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_NONE   = 2'd1,
        ST_CLOSED = 2'd2
    } status_t;

    typedef struct packed {
        logic              we;
        logic              re;
        logic [RAM_AW-1:0] addr;
        logic [7:0]        wdata;
    } ram_req_t;

    typedef struct packed {
        status_t           status;
        logic              transferred;
        logic              rd;
        logic [BELL_W-1:0] doorbell;
        logic              wake;
        logic              peer_closed;
        logic              pending;
        logic              fully_closed;
    } res_t;

    // Position mask of a ring for a capacity log2 setting, clamped to range.
    function automatic logic [RING_AW-1:0] ring_mask(input logic [CFG_W-1:0] lg);
        logic [CFG_W-1:0] l;
        logic [RING_AW:0] span;
        l = lg;
        if (l < CFG_W'(LOG2_LO)) l = CFG_W'(LOG2_LO);
        if (l > CFG_W'(LOG2_HI)) l = CFG_W'(LOG2_HI);
        span = ({{RING_AW{1'b0}}, 1'b1} << l) - {{RING_AW{1'b0}}, 1'b1};
        return span[RING_AW-1:0];
    endfunction

endpackage
`default_nettype wire

/* hdl/duplex_ring_mailbox_top.sv */
`default_nettype none
// Two-sided byte mailbox over four rings (control and bulk toward each peer)
// with doorbells, waiting flags and close bits. Each transaction on the s_
// channel is one operation and yields exactly one result transaction on the
// m_ channel, in order. Ring bytes sit in one synchronous single-port RAM of
// 4 x 4096 bytes with a registered read; head/tail counters and flags sit in
// registers and are updated at accept, so the next operation can follow in
// the very next cycle: sustained rate is one transaction per clock whenever
// m_tready is high, and a result is presented once it has passed the read
// stage register and then the output register (the RAM read lands at the
// accept edge, and the output register loads when it is free). Back-pressure
// on the m_ side stalls s_tready after two results are held. The ring RAM is
// not cleared at reset; reading is only ever done from entries already written.
// Write the capacity registers only while the block is idle.
module duplex_ring_mailbox_top (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // configuration write port
    input  wire logic                              cfg_wr_en,
    input  wire logic [drm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [drm_pkg::CFG_W-1:0]         cfg_data,
    // operation channel
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // [2:0] operation, [3] side, [4] ring_class, [12:5] byte_in
    input  wire logic [drm_pkg::IN_TDATA_W-1:0]    s_tdata,
    // result channel
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // [1:0] status, [2] transferred, [10:3] byte_out, [42:11] doorbell_count,
    // [43] wake_peer, [44] peer_closed, [45] pending, [46] fully_closed
    output logic [drm_pkg::OUT_TDATA_W-1:0]        m_tdata
);

    logic              item_fire;
    logic              stage_ready;
    drm_pkg::ram_req_t ram_req;
    drm_pkg::res_t     res;
    logic [7:0]        ram_rdata;

    // accept whenever the read stage is free or draining this cycle
    assign s_tready  = stage_ready;
    assign item_fire = s_tvalid & stage_ready;

    drm_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .item_fire  (item_fire),
        .op         (s_tdata[2:0]),
        .side       (s_tdata[3]),
        .ring_class (s_tdata[4]),
        .byte_in    (s_tdata[12:5]),
        .ram_req    (ram_req),
        .res        (res)
    );

    drm_byte_ram #(
        .DATA_W (8),
        .ADDR_W (drm_pkg::RAM_AW)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_req.we),
        .re    (ram_req.re),
        .addr  (ram_req.addr),
        .wdata (ram_req.wdata),
        .rdata (ram_rdata)
    );

    // hold the per-item result while the RAM read lands, then register it out
    drm_out_stage u_out (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .item_fire   (item_fire),
        .res         (res),
        .ram_rdata   (ram_rdata),
        .stage_ready (stage_ready),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

endmodule
`default_nettype wire

/* hdl/drm_byte_ram.sv */
`default_nettype none
module drm_byte_ram #(
    parameter int DATA_W = 8,
    parameter int ADDR_W = 14
) (
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] addr,
    input  wire logic [DATA_W-1:0] wdata,
    output logic      [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [2**ADDR_W];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        if (re) begin
            rdata <= mem[addr];
        end
    end

endmodule
`default_nettype wire

/* hdl/drm_ctrl.sv */
`default_nettype none
module drm_ctrl (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_wr_en,
    input  wire logic [drm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [drm_pkg::CFG_W-1:0]     cfg_data,
    input  wire logic                          item_fire,
    input  wire logic [2:0]                    op,
    input  wire logic                          side,
    input  wire logic                          ring_class,
    input  wire logic [7:0]                    byte_in,
    output drm_pkg::ram_req_t                  ram_req,
    output drm_pkg::res_t                      res
);

    logic [drm_pkg::CFG_W-1:0] ctrl_log2_reg, bulk_log2_reg;

    logic [drm_pkg::CNT_W-1:0] head_reg [drm_pkg::NUM_RINGS];
    logic [drm_pkg::CNT_W-1:0] head_next [drm_pkg::NUM_RINGS];
    logic [drm_pkg::CNT_W-1:0] tail_reg [drm_pkg::NUM_RINGS];
    logic [drm_pkg::CNT_W-1:0] tail_next [drm_pkg::NUM_RINGS];
    logic [drm_pkg::NUM_RINGS-1:0] blocked_reg, blocked_next;
    logic [1:0] close_reg, close_next;
    logic [1:0] waiting_reg, waiting_next;
    logic [drm_pkg::BELL_W-1:0] bell_reg [2];
    logic [drm_pkg::BELL_W-1:0] bell_next [2];

    logic                            peer;
    logic [drm_pkg::RING_IDX_W-1:0]  ring;
    logic [drm_pkg::RING_AW-1:0]     mask;
    logic [drm_pkg::CNT_W-1:0]       used;
    logic [drm_pkg::CNT_W-1:0]       head_cur, tail_cur;
    logic                            ring_bell;
    logic                            pend;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_log2_reg <= drm_pkg::CAP_LOG2_RESET;
            bulk_log2_reg <= drm_pkg::CAP_LOG2_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                drm_pkg::REG_CONTROL_CAP: ctrl_log2_reg <= cfg_data;
                drm_pkg::REG_BULK_CAP:    bulk_log2_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign peer     = ~side;
    assign ring     = (drm_pkg::op_t'(op) == drm_pkg::OP_WRITE) ? {side, ring_class}
                                                                : {peer, ring_class};
    assign mask     = drm_pkg::ring_mask(ring_class ? bulk_log2_reg : ctrl_log2_reg);
    assign head_cur = head_reg[ring];
    assign tail_cur = tail_reg[ring];
    assign used     = head_cur - tail_cur;

    always_comb begin
        head_next    = head_reg;
        tail_next    = tail_reg;
        blocked_next = blocked_reg;
        close_next   = close_reg;
        waiting_next = waiting_reg;
        bell_next    = bell_reg;
        ring_bell    = 1'b0;
        ram_req      = '0;
        res          = '0;
        res.status   = drm_pkg::ST_OK;
        ram_req.wdata = byte_in;

        case (drm_pkg::op_t'(op))
            drm_pkg::OP_WRITE: begin
                ram_req.addr = {ring, head_cur[drm_pkg::RING_AW-1:0] & mask};
                if (close_reg != 2'b00) begin
                    res.status = drm_pkg::ST_CLOSED;
                end else if (used > {1'b0, mask}) begin
                    blocked_next[ring] = 1'b1;
                    res.status         = drm_pkg::ST_NONE;
                end else begin
                    ram_req.we      = item_fire;
                    head_next[ring] = head_cur + drm_pkg::CNT_W'(1);
                    res.transferred = 1'b1;
                    ring_bell       = 1'b1;
                end
            end
            drm_pkg::OP_READ: begin
                ram_req.addr = {ring, tail_cur[drm_pkg::RING_AW-1:0] & mask};
                if (used == '0) begin
                    res.status = close_reg[peer] ? drm_pkg::ST_CLOSED : drm_pkg::ST_NONE;
                end else begin
                    ram_req.re      = item_fire;
                    tail_next[ring] = tail_cur + drm_pkg::CNT_W'(1);
                    res.transferred = 1'b1;
                    res.rd          = 1'b1;
                    if (blocked_reg[ring]) begin
                        blocked_next[ring] = 1'b0;
                        ring_bell          = 1'b1;
                    end
                end
            end
            drm_pkg::OP_CLOSE: begin
                if (!close_reg[side]) begin
                    close_next[side] = 1'b1;
                    ring_bell        = 1'b1;
                end
            end
            drm_pkg::OP_PREPARE: begin
                waiting_next[side] = 1'b1;
                res.doorbell       = bell_reg[side];
            end
            drm_pkg::OP_FINISH: begin
                waiting_next[side] = 1'b0;
            end
            default: ;
        endcase

        // Every bell rung by an item goes to the peer of the issuer.
        if (ring_bell) begin
            bell_next[peer] = bell_reg[peer] + drm_pkg::BELL_W'(1);
            res.wake        = waiting_reg[peer];
        end

        pend = (head_next[{peer, 1'b0}] != tail_next[{peer, 1'b0}])
            || (head_next[{peer, 1'b1}] != tail_next[{peer, 1'b1}]);
        res.peer_closed  = close_next[peer];
        res.pending      = pend;
        res.fully_closed = close_next[peer] & ~pend;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < drm_pkg::NUM_RINGS; i++) begin
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
            end
            blocked_reg <= '0;
            close_reg   <= '0;
            waiting_reg <= '0;
            bell_reg[0] <= '0;
            bell_reg[1] <= '0;
        end else if (item_fire) begin
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            blocked_reg <= blocked_next;
            close_reg   <= close_next;
            waiting_reg <= waiting_next;
            bell_reg    <= bell_next;
        end
    end

endmodule
`default_nettype wire

/* hdl/drm_out_stage.sv */
`default_nettype none
module drm_out_stage (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              item_fire,
    input  wire drm_pkg::res_t                     res,
    input  wire logic [7:0]                        ram_rdata,
    output logic                                   stage_ready,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [drm_pkg::OUT_TDATA_W-1:0]        m_tdata
);

    logic          s1_valid_reg, s1_valid_next;
    drm_pkg::res_t s1_res_reg;
    logic          out_valid_reg, out_valid_next;
    logic [drm_pkg::OUT_TDATA_W-1:0] out_data_reg, out_data_next;
    logic          s1_advance;
    logic [7:0]    byte_out;

    assign s1_advance  = s1_valid_reg & (~out_valid_reg | m_tready);
    assign stage_ready = ~s1_valid_reg | s1_advance;
    assign byte_out    = s1_res_reg.rd ? ram_rdata : 8'd0;

    always_comb begin
        s1_valid_next  = s1_valid_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end
        if (s1_advance) begin
            s1_valid_next  = 1'b0;
            out_valid_next = 1'b1;
            out_data_next  = {1'b0,
                              s1_res_reg.fully_closed,
                              s1_res_reg.pending,
                              s1_res_reg.peer_closed,
                              s1_res_reg.wake,
                              s1_res_reg.doorbell,
                              byte_out,
                              s1_res_reg.transferred,
                              s1_res_reg.status};
        end
        if (item_fire) begin
            s1_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
        if (item_fire) begin
            s1_res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule
`default_nettype wire

/* hdl/drm_checker.sv */
`default_nettype none
module drm_checker (
    input wire logic                           aclk,
    input wire logic                           aresetn,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready,
    input wire logic [drm_pkg::OUT_TDATA_W-1:0] m_tdata
);

    // no result survives a reset
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // a moved byte always reports ok
    a_moved_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[2] |-> m_tdata[1:0] == 2'd0)
        else $error("transfer with non-ok status");

    // fully closed means peer closed and nothing pending
    a_fully_closed: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[46] |-> m_tdata[44] && !m_tdata[45])
        else $error("fully_closed inconsistent");

    // byte_out is zero unless a byte moved
    a_byte_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[2] |-> m_tdata[10:3] == 8'd0)
        else $error("byte_out set without transfer");

endmodule

bind duplex_ring_mailbox_top drm_checker u_drm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire
